// ===== rtl/core/rtc2e_pkg.sv =====
// Shared types, status codes and calendar tables for the RTC snapshot to epoch converter.
package rtc2e_pkg;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_HALTED      = 3'd1,
    ST_BAD_BCD     = 3'd2,
    ST_BAD_FIELD   = 3'd3,
    ST_IMPLAUSIBLE = 3'd4
  } status_t;

  // Register index as decoded from paddr[2].
  localparam logic REG_MIN_YEAR = 1'b0;
  localparam logic REG_MAX_YEAR = 1'b1;

  localparam logic [11:0] MIN_YEAR_RESET = 12'd2020;
  localparam logic [11:0] MAX_YEAR_RESET = 12'd2099;
  localparam logic [11:0] BASE_YEAR      = 12'd2000;
  localparam logic [15:0] DAYS_TO_2000   = 16'd10957;

  typedef struct packed {
    logic [11:0] min_year;
    logic [11:0] max_year;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] days;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } decoded_t;

  function automatic logic bcd_ok(input logic [7:0] v);
    return (v[7:4] <= 4'd9) && (v[3:0] <= 4'd9);
  endfunction

  // Binary value of a masked BCD byte whose high digit is at most 9.
  function automatic logic [6:0] bcd_bin(input logic [7:0] v);
    logic [6:0] hi;
    hi = {3'b000, v[7:4]};
    return (hi << 3) + (hi << 1) + {3'b000, v[3:0]};
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m);
    case (m)
      4'd1:    return 5'd31;
      4'd2:    return 5'd28;
      4'd3:    return 5'd31;
      4'd4:    return 5'd30;
      4'd5:    return 5'd31;
      4'd6:    return 5'd30;
      4'd7:    return 5'd31;
      4'd8:    return 5'd31;
      4'd9:    return 5'd30;
      4'd10:   return 5'd31;
      4'd11:   return 5'd30;
      4'd12:   return 5'd31;
      default: return 5'd0;
    endcase
  endfunction

  function automatic logic [8:0] month_start(input logic [3:0] m);
    case (m)
      4'd1:    return 9'd0;
      4'd2:    return 9'd31;
      4'd3:    return 9'd59;
      4'd4:    return 9'd90;
      4'd5:    return 9'd120;
      4'd6:    return 9'd151;
      4'd7:    return 9'd181;
      4'd8:    return 9'd212;
      4'd9:    return 9'd243;
      4'd10:   return 9'd273;
      4'd11:   return 9'd304;
      4'd12:   return 9'd334;
      default: return 9'd0;
    endcase
  endfunction

endpackage

// ===== rtl/core/bcd_rtc_registers_to_epoch.sv =====
// Top level of the RTC register snapshot to Unix seconds converter.
//
// One input item on the s_t* channel is a snapshot of six RTC register bytes;
// one result item on the m_t* channel carries a status code in m_tuser and the
// Unix seconds in m_tdata (zero unless the status is ok).
// The block is a three-register pipeline: the snapshot is captured, decoded
// and checked into a middle register, and the seconds are formed from the day
// count and time of day into the output register. Each accepted item passes
// through the middle and then the output register before m_tvalid rises; one
// item is accepted every cycle unless m_tready stalls the output. The rate is
// set by the single decode pass and the 86400 multiply between registers.
// When the receiver holds m_tready low, the stages behind the output fill in
// turn, so up to two more items are accepted before s_tready falls; nothing is
// dropped and the held result stays stable.
// Reset clears all stage valid flags and loads the year window with
// 2020..2099. The year window registers are written through the APB port at
// byte address 0 (min) and 4 (max), and should only be written while idle.
module bcd_rtc_registers_to_epoch (
  input  logic        clk,
  input  logic        rst,
  // Input item: seconds_reg, minutes_reg, hours_reg, date_reg, month_reg,
  // year_reg, eight bits each from the lowest bit up.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,
  // Result item: m_tdata holds epoch_seconds; m_tuser holds status.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  output logic [2:0]  m_tuser,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rtc2e_pkg::*;

  cfg_t        cfg;
  logic        in_valid, mid_valid;
  logic [47:0] in_snap;
  decoded_t    dec_comb, dec_q;
  logic [31:0] epoch_comb;
  logic        out_adv, mid_adv;

  // A stage may load whenever it is empty or its content moves on.
  assign out_adv  = !m_tvalid || m_tready;
  assign mid_adv  = !mid_valid || out_adv;
  assign s_tready = !in_valid || mid_adv;

  rtc2e_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_snap <= s_tdata;
    end
  end

  rtc2e_decode u_decode (
    .snap (in_snap),
    .cfg  (cfg),
    .dec  (dec_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (mid_adv) begin
      mid_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_adv && in_valid) begin
      dec_q <= dec_comb;
    end
  end

  rtc2e_epoch u_epoch (
    .dec   (dec_q),
    .epoch (epoch_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_tvalid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && mid_valid) begin
      m_tdata <= epoch_comb;
      m_tuser <= dec_q.status;
    end
  end

  // A failed check never reports a nonzero time.
  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_OK) |-> (m_tdata == 32'd0))
    else $error("nonzero seconds with error status");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser <= ST_IMPLAUSIBLE))
    else $error("status code out of range");

  // A free output always lets a new snapshot in.
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    out_adv |-> s_tready)
    else $error("input stalled while output free");

  a_cfg_min_write: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && (paddr[2] == REG_MIN_YEAR)
    |=> (cfg.min_year == $past(pwdata[11:0])))
    else $error("min year write lost");

  a_cfg_max_write: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && (paddr[2] == REG_MAX_YEAR)
    |=> (cfg.max_year == $past(pwdata[11:0])))
    else $error("max year write lost");

endmodule

// ===== rtl/core/rtc2e_cfg.sv =====
// APB register file holding the plausible year window.
module rtc2e_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output rtc2e_pkg::cfg_t    cfg
);
  import rtc2e_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_year <= MIN_YEAR_RESET;
      cfg.max_year <= MAX_YEAR_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_MIN_YEAR: cfg.min_year <= pwdata[11:0];
        REG_MAX_YEAR: cfg.max_year <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // The low two address bits are ignored; registers are word aligned.
  always_comb begin
    case (paddr[2])
      REG_MIN_YEAR: prdata = {20'd0, cfg.min_year};
      REG_MAX_YEAR: prdata = {20'd0, cfg.max_year};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/core/rtc2e_decode.sv =====
// BCD decode, field checks and day count for one register snapshot.
module rtc2e_decode (
  input  logic [47:0]          snap,
  input  rtc2e_pkg::cfg_t      cfg,
  output rtc2e_pkg::decoded_t  dec
);
  import rtc2e_pkg::*;

  logic [7:0]  sreg, mreg, hreg, dreg, moreg, yreg;
  logic [7:0]  hmasked;
  logic        mode12, pm, leap, all_bcd_ok;
  logic [6:0]  sec_raw, min_raw, hour_raw, day_raw, mon_raw, yoff;
  logic [4:0]  hour_base, hour_cnv;
  logic        hour_bad, mon_bad, day_bad;
  logic [3:0]  mon;
  logic [4:0]  dim;
  logic [11:0] year;
  logic [7:0]  yoff_up;

  assign sreg  = snap[7:0];
  assign mreg  = snap[15:8];
  assign hreg  = snap[23:16];
  assign dreg  = snap[31:24];
  assign moreg = snap[39:32];
  assign yreg  = snap[47:40];

  assign mode12  = hreg[6];
  assign pm      = hreg[5];
  assign hmasked = mode12 ? {3'b000, hreg[4:0]} : {2'b00, hreg[5:0]};

  assign all_bcd_ok = bcd_ok({1'b0, sreg[6:0]}) && bcd_ok({1'b0, mreg[6:0]}) &&
                      bcd_ok(hmasked) && bcd_ok({2'b00, dreg[5:0]}) &&
                      bcd_ok({3'b000, moreg[4:0]}) && bcd_ok(yreg);

  assign sec_raw  = bcd_bin({1'b0, sreg[6:0]});
  assign min_raw  = bcd_bin({1'b0, mreg[6:0]});
  assign hour_raw = bcd_bin(hmasked);
  assign day_raw  = bcd_bin({2'b00, dreg[5:0]});
  assign mon_raw  = bcd_bin({3'b000, moreg[4:0]});
  assign yoff     = bcd_bin(yreg);

  // 12-hour mode: twelve o'clock counts as zero and PM adds twelve.
  assign hour_base = (hour_raw == 7'd12) ? 5'd0 : hour_raw[4:0];
  assign hour_cnv  = mode12 ? (hour_base + (pm ? 5'd12 : 5'd0)) : hour_raw[4:0];
  assign hour_bad  = mode12 ? ((hour_raw < 7'd1) || (hour_raw > 7'd12))
                            : (hour_raw > 7'd23);

  // Within 2000..2099 the Gregorian rule reduces to a multiple of four.
  assign year    = BASE_YEAR + {5'd0, yoff};
  assign leap    = (yoff[1:0] == 2'b00);
  assign mon     = mon_raw[3:0];
  assign mon_bad = (mon_raw < 7'd1) || (mon_raw > 7'd12);
  assign dim     = month_len(mon) + {4'd0, (mon == 4'd2) && leap};
  assign day_bad = (day_raw < 7'd1) || (day_raw > {2'b00, dim});
  assign yoff_up = {1'b0, yoff} + 8'd3;

  always_comb begin
    if (sreg[7]) begin
      dec.status = ST_HALTED;
    end else if (!all_bcd_ok) begin
      dec.status = ST_BAD_BCD;
    end else if (hour_bad || mon_bad || day_bad ||
                 (min_raw > 7'd59) || (sec_raw > 7'd59)) begin
      dec.status = ST_BAD_FIELD;
    end else if ((year < cfg.min_year) || (year > cfg.max_year)) begin
      dec.status = ST_IMPLAUSIBLE;
    end else begin
      dec.status = ST_OK;
    end
  end

  assign dec.days = DAYS_TO_2000 + ({9'd0, yoff} * 16'd365) + {10'd0, yoff_up[7:2]} +
                    {7'd0, month_start(mon)} + {15'd0, (mon > 4'd2) && leap} +
                    {9'd0, day_raw} - 16'd1;
  assign dec.hour   = hour_cnv;
  assign dec.minute = min_raw[5:0];
  assign dec.second = sec_raw[5:0];

endmodule

// ===== rtl/core/rtc2e_epoch.sv =====
// Converts a day count and time of day into Unix seconds.
module rtc2e_epoch (
  input  rtc2e_pkg::decoded_t  dec,
  output logic [31:0]          epoch
);
  import rtc2e_pkg::*;

  logic [31:0] sum;

  assign sum = ({16'd0, dec.days} * 32'd86400) + ({27'd0, dec.hour} * 32'd3600) +
               ({26'd0, dec.minute} * 32'd60) + {26'd0, dec.second};

  // Any failed check reports zero seconds.
  assign epoch = (dec.status == ST_OK) ? sum : 32'd0;

endmodule
